FILE: hdl/pcfrm_pkg.sv
// ============================================================================
// pcfrm_pkg: shared types and constants of the frame rate meter
// Field widths, command and status codes, and fixed-point scale factors.
// ============================================================================
package pcfrm_pkg;

    // Field widths
    localparam int CAM_W      = 4;
    localparam int CCOUNT_W   = 5;
    localparam int TS_W       = 32;
    localparam int CEIL_W     = 17;
    localparam int RATE_W     = 25;
    localparam int STATUS_W   = 2;

    // 1000 ms/s times 256 fractional steps per fps
    localparam int RATE_SCALE = 256000;
    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int CMD_KIND_W  = 2;
    // kind + tstamp + ceiling + has_ceiling + status
    localparam int CMD_FIXED_W = CMD_KIND_W + TS_W + CEIL_W + 1 + STATUS_W;

    // Input item kinds
    localparam logic ACT_CAPTURE = 1'b0;
    localparam logic ACT_QUERY   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NOT_ALLOC  = 2'd1,
        ST_NO_SAMPLES = 2'd2,
        ST_ZERO_SPAN  = 2'd3
    } status_t;

    typedef enum logic [CMD_KIND_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_SCAN   = 2'd1,
        CMD_STATUS = 2'd2
    } cmd_kind_t;

endpackage

FILE: hdl/pcfrm_ram.sv
// ============================================================================
// pcfrm_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module pcfrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1600,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/pcfrm_div.sv
// ============================================================================
// pcfrm_div: bit-serial restoring divider
// Unsigned NW-bit numerator by 32-bit denominator, one quotient bit per cycle.
// ============================================================================
module pcfrm_div #(
    parameter int NW = 25
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] numer,
    input  logic [31:0]   denom,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int SW = $clog2(NW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [SW-1:0] step_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   den_reg;
    logic [NW-1:0] quo_reg;

    logic [32:0]   shifted;
    logic [32:0]   diff;
    logic          fits;

    // Trial subtraction of one step
    always_comb begin
        shifted = {rem_reg, quo_reg[NW-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = (shifted >= {1'b0, den_reg});
    end

    // Iteration; numerator bits shift out as quotient bits shift in
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= SW'(NW);
                rem_reg  <= '0;
                quo_reg  <= numer;
                den_reg  <= denom;
            end else if (busy_reg) begin
                rem_reg  <= fits ? diff[31:0] : shifted[31:0];
                quo_reg  <= {quo_reg[NW-2:0], fits};
                step_reg <= step_reg - 1'b1;
                if (step_reg == SW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hdl/pcfrm_front.sv
// ============================================================================
// pcfrm_front: item intake and classification
// Tracks ring positions and sample counts, turns items into commands (captures for unallocated cameras are dropped).
// ============================================================================
module pcfrm_front #(
    parameter int CAMERAS = 16,
    parameter int WINDOW  = 100,
    localparam int AW    = $clog2(CAMERAS * WINDOW),
    localparam int CW    = $clog2(WINDOW + 1),
    localparam int CMD_W = AW + CW + pcfrm_pkg::CMD_FIXED_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [pcfrm_pkg::CCOUNT_W-1:0] cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_action,
    input  logic [pcfrm_pkg::CAM_W-1:0]   in_camera,
    input  logic [pcfrm_pkg::TS_W-1:0]    in_tstamp,
    input  logic [pcfrm_pkg::CEIL_W-1:0]  in_ceiling,
    input  logic                          in_has_ceiling,
    input  logic                          q_full,
    output logic                          push,
    output logic [CMD_W-1:0]              push_data
);

    import pcfrm_pkg::*;

    localparam int PW = $clog2(WINDOW);
    localparam int IW = (CAMERAS > 1) ? $clog2(CAMERAS) : 1;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [AW-1:0]     addr;
        logic [TS_W-1:0]   tstamp;
        logic [CW-1:0]     cnt;
        logic [CEIL_W-1:0] ceiling;
        logic              has_ceiling;
        status_t           status;
    } cmd_t;

    logic [CCOUNT_W-1:0] cam_count_reg;
    logic [PW-1:0]       pos_reg [CAMERAS];
    logic [CW-1:0]       cnt_reg [CAMERAS];

    logic          accept;
    logic          allocated;
    logic [IW-1:0] cam_idx;
    logic [PW-1:0] pos_cur;
    logic [PW-1:0] pos_next;
    logic [CW-1:0] cnt_cur;
    logic [CW-1:0] cnt_next;
    logic [AW-1:0] base;
    cmd_t          cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    // Per-camera lookup and ring arithmetic
    always_comb begin
        cam_idx   = IW'(in_camera);
        allocated = ({1'b0, in_camera} < cam_count_reg) &&
                    (32'(in_camera) < 32'(CAMERAS));
        pos_cur   = pos_reg[cam_idx];
        cnt_cur   = cnt_reg[cam_idx];
        pos_next  = (pos_cur == PW'(WINDOW - 1)) ? '0 : pos_cur + 1'b1;
        cnt_next  = (cnt_cur < CW'(WINDOW)) ? cnt_cur + 1'b1 : cnt_cur;
        base      = AW'(cam_idx) * AW'(WINDOW);
    end

    // Command build
    always_comb begin
        cmd             = '0;
        cmd.kind        = CMD_STATUS;
        cmd.addr        = base;
        cmd.tstamp      = in_tstamp;
        cmd.ceiling     = in_ceiling;
        cmd.has_ceiling = in_has_ceiling;
        cmd.status      = ST_OK;
        priority if (in_action == ACT_CAPTURE) begin
            cmd.kind = CMD_WRITE;
            cmd.addr = base + AW'(pos_cur);
        end else if (!allocated) begin
            cmd.status = ST_NOT_ALLOC;
        end else if (cnt_cur == '0) begin
            cmd.status = ST_NO_SAMPLES;
        end else begin
            cmd.kind = CMD_SCAN;
            cmd.cnt  = cnt_cur;
        end
    end

    // Captures for unallocated cameras vanish here
    assign push      = accept && ((in_action == ACT_QUERY) || allocated);
    assign push_data = cmd;

    // Register, ring positions and counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_count_reg <= '0;
            for (int i = 0; i < CAMERAS; i++) begin
                pos_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end else if (cfg_wen) begin
            cam_count_reg <= cfg_wdata;
            for (int i = 0; i < CAMERAS; i++) begin
                pos_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end else if (accept && (in_action == ACT_CAPTURE) && allocated) begin
            pos_reg[cam_idx] <= pos_next;
            cnt_reg[cam_idx] <= cnt_next;
        end
    end

    a_ring_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && allocated) |-> (cnt_cur <= CW'(WINDOW) && 32'(pos_cur) < WINDOW))
        else $error("ring position or count out of range");

    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wen |=> (cnt_reg[0] == '0 && pos_reg[0] == '0))
        else $error("register write did not clear rings");

endmodule

FILE: hdl/pcfrm_queue.sv
// ============================================================================
// pcfrm_queue: command FIFO between front and back
// Small register FIFO; head entry is visible combinationally.
// ============================================================================
module pcfrm_queue #(
    parameter int W = 80
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] pop_data
);

    import pcfrm_pkg::*;

    localparam int PTRW = $clog2(QUEUE_DEPTH);

    logic [W-1:0]    mem [QUEUE_DEPTH];
    logic [PTRW-1:0] wr_ptr_reg;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [PTRW:0]   count_reg;

    assign full     = (count_reg == (PTRW + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> !full)
        else $error("command queue overflow");

endmodule

FILE: hdl/pcfrm_back.sv
// ============================================================================
// pcfrm_back: command execution
// Writes timestamps, scans a ring for min/max, divides, holds the result.
// ============================================================================
module pcfrm_back #(
    parameter int CAMERAS = 16,
    parameter int WINDOW  = 100,
    localparam int AW    = $clog2(CAMERAS * WINDOW),
    localparam int CW    = $clog2(WINDOW + 1),
    localparam int CMD_W = AW + CW + pcfrm_pkg::CMD_FIXED_W
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_empty,
    input  logic [CMD_W-1:0]             q_data,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pcfrm_pkg::RATE_W-1:0] out_rate,
    output pcfrm_pkg::status_t           out_status
);

    import pcfrm_pkg::*;

    localparam int NW = $clog2(RATE_SCALE * WINDOW + 1);
    localparam int QW = (NW > RATE_W) ? NW : RATE_W;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [AW-1:0]     addr;
        logic [TS_W-1:0]   tstamp;
        logic [CW-1:0]     cnt;
        logic [CEIL_W-1:0] ceiling;
        logic              has_ceiling;
        status_t           status;
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DIVIDE,
        S_RESULT
    } state_t;

    state_t              state_reg;
    logic [AW-1:0]       base_reg;
    logic [CW-1:0]       n_reg;
    logic [CW-1:0]       idx_reg;
    logic                rd_pend_reg;
    logic                first_reg;
    logic [TS_W-1:0]     lo_reg;
    logic [TS_W-1:0]     hi_reg;
    logic [CEIL_W-1:0]   ceil_reg;
    logic                has_reg;
    logic [NW-1:0]       numer_reg;
    logic [RATE_W-1:0]   res_rate_reg;
    status_t             res_status_reg;
    logic                out_valid_reg;
    logic [RATE_W-1:0]   out_rate_reg;
    status_t             out_status_reg;

    cmd_t                cmd;
    logic                ram_we;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [TS_W-1:0]     ram_rdata;
    logic [TS_W-1:0]     span;
    logic                scan_end;
    logic                div_start;
    logic                div_done;
    logic [NW-1:0]       div_quotient;
    logic [QW-1:0]       q_ext;
    logic [QW-1:0]       cap_ext;
    logic [QW-1:0]       rate_capped;
    logic [QW-1:0]       rate_sat;
    logic                out_free;

    // Command decode and RAM control
    always_comb begin
        cmd       = cmd_t'(q_data);
        q_pop     = (state_reg == S_IDLE) && !q_empty;
        ram_we    = q_pop && (cmd.kind == CMD_WRITE);
        ram_re    = (state_reg == S_SCAN) && (idx_reg < n_reg);
        ram_raddr = base_reg + AW'(idx_reg);
        span      = hi_reg - lo_reg;
        scan_end  = (state_reg == S_SCAN) && (idx_reg == n_reg) && !rd_pend_reg;
        div_start = scan_end && (span != '0);
        out_free  = !out_valid_reg || out_ready;
    end

    // Ceiling and saturation on the quotient
    always_comb begin
        q_ext       = QW'(div_quotient);
        cap_ext     = QW'({ceil_reg, 8'b0});
        rate_capped = (has_reg && (q_ext > cap_ext)) ? cap_ext : q_ext;
        rate_sat    = (rate_capped > QW'(RATE_MAX)) ? QW'(RATE_MAX) : rate_capped;
    end

    pcfrm_ram #(
        .WIDTH (TS_W),
        .DEPTH (CAMERAS * WINDOW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cmd.addr),
        .wdata (cmd.tstamp),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pcfrm_div #(
        .NW (NW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .numer    (numer_reg),
        .denom    (span),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer, min/max fold and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            // Output valid: set as a result moves out, cleared on its transfer
            if ((state_reg == S_RESULT) && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end

            // Read data lands in the cycle after the address
            rd_pend_reg <= ram_re;
            if (rd_pend_reg) begin
                if (first_reg) begin
                    lo_reg    <= ram_rdata;
                    hi_reg    <= ram_rdata;
                    first_reg <= 1'b0;
                end else begin
                    if (ram_rdata < lo_reg) begin
                        lo_reg <= ram_rdata;
                    end
                    if (ram_rdata > hi_reg) begin
                        hi_reg <= ram_rdata;
                    end
                end
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        unique case (cmd.kind)
                            CMD_SCAN: begin
                                base_reg  <= cmd.addr;
                                n_reg     <= cmd.cnt;
                                idx_reg   <= '0;
                                first_reg <= 1'b1;
                                ceil_reg  <= cmd.ceiling;
                                has_reg   <= cmd.has_ceiling;
                                numer_reg <= NW'(32'(cmd.cnt) * 32'(RATE_SCALE));
                                state_reg <= S_SCAN;
                            end
                            CMD_STATUS: begin
                                res_rate_reg   <= '0;
                                res_status_reg <= cmd.status;
                                state_reg      <= S_RESULT;
                            end
                            default: begin
                                // timestamp writes complete in this cycle
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (ram_re) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (scan_end) begin
                        if (span == '0) begin
                            res_rate_reg   <= '0;
                            res_status_reg <= ST_ZERO_SPAN;
                            state_reg      <= S_RESULT;
                        end else begin
                            state_reg <= S_DIVIDE;
                        end
                    end
                end
                S_DIVIDE: begin
                    if (div_done) begin
                        res_rate_reg   <= rate_sat[RATE_W-1:0];
                        res_status_reg <= ST_OK;
                        state_reg      <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        out_rate_reg   <= res_rate_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_rate   = out_rate_reg;
    assign out_status = out_status_reg;

    a_scan_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (idx_reg <= n_reg))
        else $error("scan index ran past sample count");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIVIDE))
        else $error("divider finished outside divide state");

    a_result_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESULT && out_valid_reg && !out_ready) |=> (state_reg == S_RESULT))
        else $error("result left while output register was held");

endmodule

FILE: hdl/per_camera_frame_rate_meter.sv
// ============================================================================
// per_camera_frame_rate_meter: sliding-window frame rate meter
// Ring of capture timestamps per camera; queries return the windowed rate.
// ============================================================================
//
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid/s_tready    tdata: camera, timestamp_ms, rate_ceiling,
//                                    has_ceiling; tuser: action
// m_       out  m_tvalid/m_tready    tdata: rate_fixed; tuser: status
// cfg_     in   cfg_wen              cfg_wdata: camera_count
//
// A capture passes the front combinationally and is written to the RAM when
// the back pops it. A query reads its n stored samples on the RAM read port,
// folds them to min and max, then runs the bit-serial divider (NW = 25 bits
// at WINDOW = 100). A 4-entry command queue lets the front keep accepting.
// No clearing pass after reset: the timestamp RAM is only read where written.
// s_tready drops only when the queue is full; a held output stalls the back.
//
module per_camera_frame_rate_meter #(
    parameter int CAMERAS = 16,
    parameter int WINDOW  = 100
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wen,
    input  logic [4:0]  cfg_wdata,   // [4:0] camera_count
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,     // [3:0] camera, [35:4] timestamp_ms,
                                     // [52:36] rate_ceiling, [53] has_ceiling
    input  logic [0:0]  s_tuser,     // [0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [24:0] rate_fixed
    output logic [1:0]  m_tuser      // [1:0] status
);

    import pcfrm_pkg::*;

    localparam int AW    = $clog2(CAMERAS * WINDOW);
    localparam int CW    = $clog2(WINDOW + 1);
    localparam int CMD_W = AW + CW + CMD_FIXED_W;

    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    logic [CMD_W-1:0]  q_wdata;
    logic [CMD_W-1:0]  q_rdata;
    logic [RATE_W-1:0] rate;
    status_t           status;

    pcfrm_front #(
        .CAMERAS (CAMERAS),
        .WINDOW  (WINDOW)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wen        (cfg_wen),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_action      (s_tuser[0]),
        .in_camera      (s_tdata[3:0]),
        .in_tstamp      (s_tdata[35:4]),
        .in_ceiling     (s_tdata[52:36]),
        .in_has_ceiling (s_tdata[53]),
        .q_full         (q_full),
        .push           (q_push),
        .push_data      (q_wdata)
    );

    pcfrm_queue #(
        .W (CMD_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_rdata)
    );

    pcfrm_back #(
        .CAMERAS (CAMERAS),
        .WINDOW  (WINDOW)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_rate   (rate),
        .out_status (status)
    );

    // Pack result stream
    assign m_tdata = {7'b0, rate};
    assign m_tuser = status;

endmodule
